>>> rtl/device_address_allowlist_macros.svh
// Assertion macros used by the allowlist RTL.
`ifndef DEVICE_ADDRESS_ALLOWLIST_MACROS_SVH
`define DEVICE_ADDRESS_ALLOWLIST_MACROS_SVH

`ifndef SYNTHESIS
`define DAL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allowlist assertion failed");
`define DAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allowlist assertion failed");
`else
`define DAL_ASSERT_IMP(label, ante, cons)
`define DAL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/dal_pkg.sv
// Types and constants for the device address allowlist.
`timescale 1ns / 1ps
package dal_pkg;

    localparam int ADDR_W  = 48;
    localparam int COUNT_W = 8;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;

    localparam logic [REQ_W-1:0] REQ_ADD      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CONTAINS = 3'd2;
    localparam logic [REQ_W-1:0] REQ_GET      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ADDR_W-1:0]  device_address;
        logic [COUNT_W-1:0] slot_index;
    } t_req_item;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               is_member;
        logic [ADDR_W-1:0]  address_out;
        logic [COUNT_W-1:0] entry_count;
    } t_rsp_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_RESP
    } t_state;

endpackage

>>> rtl/dal_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dal_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/device_address_allowlist.sv
// Add, remove, contains, get and clear on an allowlist of 48-bit addresses; one request a time.
// Add, contains and remove scan one entry per cycle through the RAM read port and comparator.
// A hit ends the scan at the matching entry; a miss scans every entry up to the count.
// A remove that hits also shifts the rest down; get and clear do not scan.
// A stalled response holds the sequencer; no new request is accepted until it is taken.
// Reset clears the count and sequencer; RAM contents are kept and never read past the count.
`timescale 1ns / 1ps
module device_address_allowlist #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  dal_pkg::t_req_item i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output dal_pkg::t_rsp_item o_rsp
);

    import dal_pkg::*;

    `include "device_address_allowlist_macros.svh"

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_state             r_state, n_state;
    t_req_item          r_req, n_req;
    t_rsp_item          r_res, n_res;
    logic [CW-1:0]      r_idx, n_idx;
    logic [COUNT_W-1:0] r_count, n_count;

    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [ADDR_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_rdata;
    logic [CW-1:0]     w_prev;
    logic              w_hit, w_end, w_full, w_slot_ok, w_shift_more;

    dal_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_hit        = (w_rdata == r_req.device_address);
    assign w_end        = (COUNT_W'(r_idx) >= r_count);
    assign w_full       = (r_count >= COUNT_W'(MAX_ENTRIES));
    assign w_slot_ok    = (r_req.slot_index < r_count);
    assign w_shift_more = (COUNT_W'(r_idx) < r_count);
    assign w_prev       = r_idx - CW'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_req.req_type)
                    REQ_ADD, REQ_CONTAINS: begin
                        if (w_end || w_hit) begin
                            n_state = S_RESP;
                        end
                    end
                    REQ_REMOVE: begin
                        if (w_end) begin
                            n_state = S_RESP;
                        end else if (w_hit) begin
                            n_state = S_SHIFT;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_SHIFT: begin
                if (!w_shift_more) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_req   = r_req;
        n_res   = r_res;
        n_idx   = r_idx;
        n_count = r_count;
        w_we    = 1'b0;
        w_waddr = r_count[IW-1:0];
        w_wdata = r_req.device_address;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req = i_req;
                    n_idx = (i_req.req_type == REQ_GET) ? i_req.slot_index[CW-1:0] : '0;
                end
            end
            S_EXEC: begin
                n_res        = '0;
                n_res.status = STAT_OK;
                case (r_req.req_type)
                    REQ_ADD: begin
                        if (w_end) begin
                            if (w_full) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + COUNT_W'(1);
                            end
                        end else if (!w_hit) begin
                            n_idx = r_idx + CW'(1);
                        end
                    end
                    REQ_REMOVE: begin
                        if (!w_end) begin
                            n_idx = r_idx + CW'(1);
                        end
                    end
                    REQ_CONTAINS: begin
                        if (!w_end) begin
                            if (w_hit) begin
                                n_res.is_member = 1'b1;
                            end else begin
                                n_idx = r_idx + CW'(1);
                            end
                        end
                    end
                    REQ_GET: begin
                        if (w_slot_ok) begin
                            n_res.address_out = w_rdata;
                        end else begin
                            n_res.status = STAT_NOT_FOUND;
                        end
                    end
                    REQ_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
                n_res.entry_count = n_count;
            end
            S_SHIFT: begin
                if (w_shift_more) begin
                    w_we    = 1'b1;
                    w_waddr = w_prev[IW-1:0];
                    w_wdata = w_rdata;
                    n_idx   = r_idx + CW'(1);
                end else begin
                    n_count           = r_count - COUNT_W'(1);
                    n_res.entry_count = n_count;
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_RESP);
    assign o_rsp       = r_res;

    `DAL_ASSERT_IMP(a_count_bound, 1'b1, r_count <= COUNT_W'(MAX_ENTRIES))
    `DAL_ASSERT_IMP(a_shift_nonempty, r_state == S_SHIFT, r_count != '0)
    `DAL_ASSERT_IMP(a_member_only_contains, o_rsp_valid && o_rsp.is_member, r_req.req_type == REQ_CONTAINS)
    `DAL_ASSERT_NEXT(a_clear_empties, r_state == S_EXEC && r_req.req_type == REQ_CLEAR, r_count == '0)

endmodule
